### hw/rtl/nnba_pkg.sv
package nnba_pkg;

  // field widths
  localparam int unsigned CoordW  = 12;                 // offsets, sizes, origins
  localparam int unsigned ProdW   = 2 * CoordW;         // offset times source size
  localparam int unsigned SumW    = CoordW + 2;         // origin plus offset, signed
  localparam int unsigned TgtW    = 11;
  localparam int unsigned SmpW    = 10;

  // divider layout: one quotient bit per step, StepsPerSt steps per stage
  localparam int unsigned QuotW      = CoordW;
  localparam int unsigned StepsPerSt = 2;
  localparam int unsigned DivStages  = QuotW / StepsPerSt;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEST_ORIGIN_X   = 3'd0,
    CFG_DEST_ORIGIN_Y   = 3'd1,
    CFG_DEST_WIDTH      = 3'd2,
    CFG_DEST_HEIGHT     = 3'd3,
    CFG_SOURCE_ORIGIN_X = 3'd4,
    CFG_SOURCE_ORIGIN_Y = 3'd5,
    CFG_SOURCE_WIDTH    = 3'd6,
    CFG_SOURCE_HEIGHT   = 3'd7
  } cfg_idx_e;

  // payload moving through the multiply and divide stages
  typedef struct packed {
    logic              live;      // in the rectangle and not rejected
    logic              rejected;
    logic [SumW-1:0]   tx;        // signed target column
    logic [SumW-1:0]   ty;        // signed target row
    logic [CoordW-1:0] rem_x;     // partial remainder
    logic [CoordW-1:0] rem_y;
    logic [CoordW-1:0] low_x;     // dividend bits left, quotient bits shifted in
    logic [CoordW-1:0] low_y;
  } pipe_t;

  // result held in the output register
  typedef struct packed {
    logic            write_enable;
    logic            rejected;
    logic [TgtW-1:0] target_col;
    logic [TgtW-1:0] target_row;
    logic [SmpW-1:0] sample_col;
    logic [SmpW-1:0] sample_row;
  } result_t;

  // one restoring division step: returns next remainder and quotient bit
  function automatic logic [CoordW:0] div_step(logic [CoordW-1:0] rem, logic din,
                                               logic [CoordW-1:0] dvs);
    logic [CoordW:0] t;
    logic [CoordW:0] s;
    t = {rem, din};
    s = t - {1'b0, dvs};
    if (t >= {1'b0, dvs}) begin
      return {s[CoordW-1:0], 1'b1};
    end
    return {t[CoordW-1:0], 1'b0};
  endfunction

endpackage

### hw/rtl/nearest_neighbor_blit_addresser.sv
// throughput: one pixel per cycle unless the output stalls; stages are the multiply
//   stage, six divider stages resolving two quotient bits each, then the
//   clip/compare output stage
// every stage has its own valid bit and ready, so bubbles close up under stall
// reset: all stage valids clear, sizes load 1 and origins load 0
// config writes are expected only while the pipeline is empty
module nearest_neighbor_blit_addresser import nnba_pkg::*; #(
  parameter int unsigned SURFACE_WIDTH  = 2048,
  parameter int unsigned SURFACE_HEIGHT = 2048,
  parameter int unsigned BITMAP_WIDTH   = 1024,
  parameter int unsigned BITMAP_HEIGHT  = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CoordW-1:0]  cfg_data_i,
  // pixel offset stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [23:0]        s_axis_tdata,   // offset_col[11:0], offset_row[23:12]
  // address stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [47:0]        m_axis_tdata,   // target_col[10:0], target_row[21:11],
                                             // sample_col[31:22], sample_row[41:32], zero
  output logic [1:0]         m_axis_tuser    // write_enable[0], rejected[1]
);

  // ---------------------------------------------------------------- config
  logic signed [CoordW-1:0] dox_q, doy_q, sox_q, soy_q;
  logic        [CoordW-1:0] dw_q, dh_q, sw_q, sh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dox_q <= '0;
      doy_q <= '0;
      dw_q  <= CoordW'(1);
      dh_q  <= CoordW'(1);
      sox_q <= '0;
      soy_q <= '0;
      sw_q  <= CoordW'(1);
      sh_q  <= CoordW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DEST_ORIGIN_X:   dox_q <= cfg_data_i;
        CFG_DEST_ORIGIN_Y:   doy_q <= cfg_data_i;
        CFG_DEST_WIDTH:      dw_q  <= cfg_data_i;
        CFG_DEST_HEIGHT:     dh_q  <= cfg_data_i;
        CFG_SOURCE_ORIGIN_X: sox_q <= cfg_data_i;
        CFG_SOURCE_ORIGIN_Y: soy_q <= cfg_data_i;
        CFG_SOURCE_WIDTH:    sw_q  <= cfg_data_i;
        CFG_SOURCE_HEIGHT:   sh_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- pipeline
  // stage 0 holds the products, stages 1..DivStages the divider steps
  pipe_t                 pipe_q [DivStages+1];
  pipe_t                 pipe_d [DivStages+1];
  logic [DivStages:0]    vld_q;
  logic [DivStages+1:0]  rdy;        // rdy[k] : stage k may load
  logic                  out_vld_q;
  result_t               out_q, out_d;

  assign rdy[DivStages+1] = !out_vld_q || m_axis_tready;
  for (genvar k = 0; k <= DivStages; k++) begin : g_rdy
    assign rdy[k] = !vld_q[k] || rdy[k+1];
  end
  assign s_axis_tready = rdy[0];

  // stage 0: range check, target sums and the two multiplies
  logic [CoordW-1:0] off_col, off_row;
  logic [ProdW-1:0]  prod_x, prod_y;
  logic              rej;

  assign off_col = s_axis_tdata[CoordW-1:0];
  assign off_row = s_axis_tdata[2*CoordW-1:CoordW];
  assign prod_x  = ProdW'(off_col) * ProdW'(sw_q);
  assign prod_y  = ProdW'(off_row) * ProdW'(sh_q);
  assign rej     = (dw_q == '0) || (dh_q == '0) || (sw_q == '0) || (sh_q == '0);

  always_comb begin
    pipe_d[0].live     = !rej && (off_col < dw_q) && (off_row < dh_q);
    pipe_d[0].rejected = rej;
    pipe_d[0].tx       = SumW'(dox_q) + {2'b00, off_col};
    pipe_d[0].ty       = SumW'(doy_q) + {2'b00, off_row};
    // upper half is already below the divisor for any pixel inside the rectangle
    pipe_d[0].rem_x    = prod_x[ProdW-1:CoordW];
    pipe_d[0].rem_y    = prod_y[ProdW-1:CoordW];
    pipe_d[0].low_x    = prod_x[CoordW-1:0];
    pipe_d[0].low_y    = prod_y[CoordW-1:0];
  end

  // divider stages: StepsPerSt restoring steps each, quotient shifts into low
  for (genvar k = 1; k <= DivStages; k++) begin : g_div
    always_comb begin
      logic [CoordW:0] sx;
      logic [CoordW:0] sy;
      pipe_d[k] = pipe_q[k-1];
      for (int unsigned j = 0; j < StepsPerSt; j++) begin
        sx = div_step(pipe_d[k].rem_x, pipe_d[k].low_x[CoordW-1], dw_q);
        sy = div_step(pipe_d[k].rem_y, pipe_d[k].low_y[CoordW-1], dh_q);
        pipe_d[k].rem_x = sx[CoordW:1];
        pipe_d[k].rem_y = sy[CoordW:1];
        pipe_d[k].low_x = {pipe_d[k].low_x[CoordW-2:0], sx[0]};
        pipe_d[k].low_y = {pipe_d[k].low_y[CoordW-2:0], sy[0]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int unsigned k = 1; k <= DivStages; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && s_axis_tvalid) begin
      pipe_q[0] <= pipe_d[0];
    end
    for (int unsigned k = 1; k <= DivStages; k++) begin
      if (rdy[k] && vld_q[k-1]) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  // output stage: source sums, clip against both buffers, zero when not writing
  pipe_t           last;
  logic [SumW-1:0] bx, by;
  logic            in_bounds;

  assign last = pipe_q[DivStages];
  assign bx   = SumW'(sox_q) + {2'b00, last.low_x};
  assign by   = SumW'(soy_q) + {2'b00, last.low_y};

  always_comb begin
    in_bounds = last.live
          && !last.tx[SumW-1] && (last.tx < SumW'(SURFACE_WIDTH))
          && !last.ty[SumW-1] && (last.ty < SumW'(SURFACE_HEIGHT))
          && !bx[SumW-1]      && (bx < SumW'(BITMAP_WIDTH))
          && !by[SumW-1]      && (by < SumW'(BITMAP_HEIGHT));
    out_d.write_enable = in_bounds;
    out_d.rejected     = last.rejected;
    out_d.target_col   = in_bounds ? last.tx[TgtW-1:0] : '0;
    out_d.target_row   = in_bounds ? last.ty[TgtW-1:0] : '0;
    out_d.sample_col   = in_bounds ? bx[SmpW-1:0] : '0;
    out_d.sample_row   = in_bounds ? by[SmpW-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (rdy[DivStages+1]) begin
      out_vld_q <= vld_q[DivStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[DivStages+1] && vld_q[DivStages]) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = {out_q.rejected, out_q.write_enable};
  assign m_axis_tdata  = {6'b0, out_q.sample_row, out_q.sample_col,
                          out_q.target_row, out_q.target_col};

  // ---------------------------------------------------------------- checks
  a_empty_out_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> s_axis_tready)
    else $error("input stalled while output register is empty");

  a_we_not_rejected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.write_enable |-> !out_q.rejected)
    else $error("write enabled on a rejected blit");

  a_zero_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_q.write_enable |->
      (out_q.target_col == '0) && (out_q.target_row == '0) &&
      (out_q.sample_col == '0) && (out_q.sample_row == '0))
    else $error("coordinates not cleared on a suppressed pixel");

  a_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.write_enable |->
      (32'(out_q.target_col) < SURFACE_WIDTH) && (32'(out_q.target_row) < SURFACE_HEIGHT) &&
      (32'(out_q.sample_col) < BITMAP_WIDTH) && (32'(out_q.sample_row) < BITMAP_HEIGHT))
    else $error("written pixel outside its buffer");

endmodule
